[hdl/ues_pkg.sv]
// Shared types, code point constants and classification tables for the emoji sequence scanner.
package ues_pkg;

	localparam logic [20:0] CP_ZWJ    = 21'h0200D;
	localparam logic [20:0] CP_VS16   = 21'h0FE0F;
	localparam logic [20:0] CP_COMBINING_KEY = 21'h020E3;
	localparam logic [20:0] CP_MOD_LO = 21'h1F3FB;
	localparam logic [20:0] CP_MOD_HI = 21'h1F3FF;
	localparam logic [20:0] CP_RI_LO  = 21'h1F1E6;
	localparam logic [20:0] CP_RI_HI  = 21'h1F1FF;
	localparam logic [20:0] CP_TAG_LO = 21'hE0020;
	localparam logic [20:0] CP_TAG_HI = 21'hE007E;
	localparam logic [20:0] CP_TAG_END = 21'hE007F;
	localparam logic [20:0] CP_BAD    = 21'h0FFFD;

	localparam int N_DFLT = 49;
	localparam int N_TEXT = 72;

	// {low, high} inclusive ranges
	localparam logic [41:0] DFLT_TAB [N_DFLT] = '{
		{21'h1F300, 21'h1F5FF}, {21'h1F600, 21'h1F64F}, {21'h1F680, 21'h1F6FF},
		{21'h1F900, 21'h1F9FF}, {21'h1FA70, 21'h1FAFF}, {21'h1F7E0, 21'h1F7EB},
		{21'h02614, 21'h02615}, {21'h02648, 21'h02653}, {21'h0267F, 21'h0267F},
		{21'h02693, 21'h02693}, {21'h026A1, 21'h026A1}, {21'h026AA, 21'h026AB},
		{21'h026BD, 21'h026BE}, {21'h026C4, 21'h026C5}, {21'h026CE, 21'h026CE},
		{21'h026D4, 21'h026D4}, {21'h026EA, 21'h026EA}, {21'h026F2, 21'h026F3},
		{21'h026F5, 21'h026F5}, {21'h026FA, 21'h026FA}, {21'h026FD, 21'h026FD},
		{21'h02705, 21'h02705}, {21'h0270A, 21'h0270B}, {21'h02728, 21'h02728},
		{21'h0274C, 21'h0274C}, {21'h0274E, 21'h0274E}, {21'h02753, 21'h02755},
		{21'h02757, 21'h02757}, {21'h02795, 21'h02797}, {21'h027B0, 21'h027B0},
		{21'h027BF, 21'h027BF}, {21'h02B1B, 21'h02B1C}, {21'h02B50, 21'h02B50},
		{21'h02B55, 21'h02B55}, {21'h0231A, 21'h0231B}, {21'h023E9, 21'h023EC},
		{21'h023F0, 21'h023F0}, {21'h023F3, 21'h023F3}, {21'h025FD, 21'h025FE},
		{21'h1F004, 21'h1F004}, {21'h1F0CF, 21'h1F0CF}, {21'h1F18E, 21'h1F18E},
		{21'h1F191, 21'h1F19A}, {21'h1F201, 21'h1F201}, {21'h1F21A, 21'h1F21A},
		{21'h1F22F, 21'h1F22F}, {21'h1F232, 21'h1F236}, {21'h1F238, 21'h1F23A},
		{21'h1F250, 21'h1F251}
	};

	localparam logic [41:0] TEXT_TAB [N_TEXT] = '{
		{21'h000A9, 21'h000A9}, {21'h000AE, 21'h000AE}, {21'h0203C, 21'h0203C},
		{21'h02049, 21'h02049}, {21'h02122, 21'h02122}, {21'h02139, 21'h02139},
		{21'h02194, 21'h02199}, {21'h021A9, 21'h021AA}, {21'h02328, 21'h02328},
		{21'h023CF, 21'h023CF}, {21'h023ED, 21'h023EF}, {21'h023F1, 21'h023F2},
		{21'h023F8, 21'h023FA}, {21'h024C2, 21'h024C2}, {21'h025AA, 21'h025AB},
		{21'h025B6, 21'h025B6}, {21'h025C0, 21'h025C0}, {21'h025FB, 21'h025FC},
		{21'h02600, 21'h02604}, {21'h0260E, 21'h0260E}, {21'h02611, 21'h02611},
		{21'h02618, 21'h02618}, {21'h0261D, 21'h0261D}, {21'h02620, 21'h02620},
		{21'h02622, 21'h02623}, {21'h02626, 21'h02626}, {21'h0262A, 21'h0262A},
		{21'h0262E, 21'h0262F}, {21'h02638, 21'h0263A}, {21'h02640, 21'h02640},
		{21'h02642, 21'h02642}, {21'h0265F, 21'h02660}, {21'h02663, 21'h02663},
		{21'h02665, 21'h02666}, {21'h02668, 21'h02668}, {21'h0267B, 21'h0267B},
		{21'h0267E, 21'h0267E}, {21'h02692, 21'h02697}, {21'h02699, 21'h02699},
		{21'h0269B, 21'h0269C}, {21'h026A0, 21'h026A7}, {21'h026B0, 21'h026B1},
		{21'h026C8, 21'h026CF}, {21'h026D1, 21'h026D1}, {21'h026D3, 21'h026D3},
		{21'h026E9, 21'h026F1}, {21'h026F4, 21'h026F4}, {21'h026F7, 21'h026F9},
		{21'h02702, 21'h02704}, {21'h02708, 21'h02709}, {21'h0270C, 21'h0270D},
		{21'h0270F, 21'h0270F}, {21'h02712, 21'h02712}, {21'h02714, 21'h02714},
		{21'h02716, 21'h02716}, {21'h0271D, 21'h0271D}, {21'h02721, 21'h02721},
		{21'h02733, 21'h02734}, {21'h02744, 21'h02744}, {21'h02747, 21'h02747},
		{21'h02763, 21'h02764}, {21'h027A1, 21'h027A1}, {21'h02934, 21'h02935},
		{21'h02B05, 21'h02B07}, {21'h03030, 21'h03030}, {21'h0303D, 21'h0303D},
		{21'h03297, 21'h03297}, {21'h03299, 21'h03299}, {21'h1F170, 21'h1F171},
		{21'h1F17E, 21'h1F17F}, {21'h1F202, 21'h1F202}, {21'h1F237, 21'h1F237}
	};

	typedef struct packed {
		logic ri;
		logic kb;
		logic dflt;
		logic md;
		logic txt;
		logic vs;
		logic kc;
		logic zwj;
		logic tag;
		logic tend;
	} cls_t;

	typedef enum logic [1:0] {OP_PUSH, OP_STEP, OP_FINAL} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic       step_end;
		cls_t       cls;
		logic [2:0] len;
	} op_hdr_t;

	typedef enum logic [1:0] {FS_PRE, FS_BYTE, FS_POST} fstage_t;
	typedef enum logic [1:0] {BS_OP, BS_RES, BS_DONE, BS_END} bstate_t;
	typedef enum logic [1:0] {EL_WAIT, EL_NONE, EL_FOUND} elem_st_t;
	typedef enum logic [2:0] {ACT_RET, ACT_DROP1, ACT_OPEN, ACT_CLOSE, ACT_EXT} act_t;

	typedef struct packed {
		elem_st_t   st;
		logic [2:0] n;
	} elem_t;

	function automatic cls_t classify(input logic [20:0] cp);
		cls_t c;
		c = '0;
		for (int i = 0; i < N_DFLT; i++)
			if (cp >= DFLT_TAB[i][41:21] && cp <= DFLT_TAB[i][20:0]) c.dflt = 1'b1;
		for (int i = 0; i < N_TEXT; i++)
			if (cp >= TEXT_TAB[i][41:21] && cp <= TEXT_TAB[i][20:0]) c.txt = 1'b1;
		c.ri   = cp >= CP_RI_LO && cp <= CP_RI_HI;
		c.md   = cp >= CP_MOD_LO && cp <= CP_MOD_HI;
		c.tag  = cp >= CP_TAG_LO && cp <= CP_TAG_HI;
		c.tend = cp == CP_TAG_END;
		c.kb   = cp == 21'h23 || cp == 21'h2A || (cp >= 21'h30 && cp <= 21'h39);
		c.vs   = cp == CP_VS16;
		c.kc   = cp == CP_COMBINING_KEY;
		c.zwj  = cp == CP_ZWJ;
		return c;
	endfunction

endpackage

[hdl/ues_opq.sv]
// Four-entry queue of classified code point beats between front and back.
module ues_opq import ues_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	input  logic [W-1:0] wr_data,
	output logic         full,
	output logic         rd_valid,
	output logic [W-1:0] rd_data,
	input  logic         pop
);
	localparam int DEPTH = 4;

	logic [W-1:0] mem_q [DEPTH];
	logic [1:0]   wp_q, rp_q;
	logic [2:0]   cnt_q;
	logic         wr, rd;

	assign full     = cnt_q == 3'(DEPTH);
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && !full;
	assign rd       = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end
endmodule

[hdl/ues_front.sv]
// Front end: byte intake, UTF-8 decode and code point classification.
module ues_front import ues_pkg::*; #(
	parameter int MAX_BYTES = 65536,
	parameter int OW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          scan_start_we,
	input  logic [15:0]   scan_start_wdata,
	input  logic [7:0]    text_byte,
	input  logic          end_of_buffer,
	input  logic          text_valid,
	output logic          text_stall,
	output logic          op_valid,
	output op_hdr_t       op_hdr,
	output logic [OW-1:0] op_off,
	input  logic          op_full
);
	localparam int CW = (OW > 16) ? OW : 16;

	logic [15:0]   scan_start_q;
	logic          cur_q, last_q, inscan_q, emitted_q;
	logic [7:0]    b_q;
	logic [OW-1:0] off_q, boff_q, dstart_q;
	fstage_t       stage_q;
	logic [1:0]    fi_q;
	logic [2:0]    dcnt_q, need_q;
	logic [7:0]    db0_q, db1_q, db2_q;

	logic          cont, lead, pre_flush, do_byte, complete;
	logic          byte_push, flush_go, byte_go, fin_go, free, load;
	logic [20:0]   byte_cp, op_cp, cp_asm;
	logic [OW-1:0] byte_off, flush_off;
	logic [2:0]    byte_len;

	assign cont = b_q[7:6] == 2'b10;
	assign lead = b_q[7:5] == 3'b110 || b_q[7:4] == 4'b1110 || b_q[7:3] == 5'b11110;
	assign pre_flush = inscan_q && dcnt_q != 3'd0 && !cont;
	assign flush_off = dstart_q + OW'(fi_q);
	assign complete = 3'(dcnt_q + 3'd1) == need_q;

	always_comb begin
		unique case (need_q)
			3'd2: cp_asm = {10'd0, db0_q[4:0], b_q[5:0]};
			3'd3: cp_asm = {5'd0, db0_q[3:0], db1_q[5:0], b_q[5:0]};
			default: cp_asm = {db0_q[2:0], db1_q[5:0], db2_q[5:0], b_q[5:0]};
		endcase
	end

	always_comb begin
		byte_push = 1'b0;
		byte_cp   = CP_BAD;
		byte_off  = off_q;
		byte_len  = 3'd1;
		if (inscan_q) begin
			if (dcnt_q != 3'd0) begin
				if (complete) begin
					byte_push = 1'b1;
					byte_cp   = cp_asm;
					byte_off  = dstart_q;
					byte_len  = need_q;
				end
			end else if (!b_q[7]) begin
				byte_push = 1'b1;
				byte_cp   = {13'd0, b_q};
			end else if (!lead) begin
				byte_push = 1'b1;
			end
		end
	end

	always_comb begin
		op_valid        = 1'b0;
		op_hdr.kind     = OP_PUSH;
		op_hdr.step_end = 1'b0;
		op_hdr.len      = 3'd1;
		op_cp           = CP_BAD;
		op_off          = flush_off;
		flush_go        = 1'b0;
		byte_go         = 1'b0;
		fin_go          = 1'b0;
		do_byte = cur_q && (stage_q == FS_BYTE || (stage_q == FS_PRE && !pre_flush));
		if (cur_q && ((stage_q == FS_PRE && pre_flush) ||
				(stage_q == FS_POST && dcnt_q != 3'd0))) begin
			op_valid = 1'b1;
			flush_go = !op_full;
		end else if (do_byte) begin
			if (byte_push) begin
				op_valid        = 1'b1;
				op_cp           = byte_cp;
				op_off          = byte_off;
				op_hdr.len      = byte_len;
				op_hdr.step_end = !last_q;
				byte_go         = !op_full;
			end else if (!last_q && emitted_q) begin
				// earlier beats of this byte need a step marker
				op_valid        = 1'b1;
				op_hdr.kind     = OP_STEP;
				op_hdr.step_end = 1'b1;
				byte_go         = !op_full;
			end else begin
				byte_go = 1'b1;
			end
		end else if (cur_q && stage_q == FS_POST) begin
			op_valid        = 1'b1;
			op_hdr.kind     = OP_FINAL;
			op_hdr.step_end = 1'b1;
			fin_go          = !op_full;
		end
		op_hdr.cls = classify(op_cp);
	end

	assign free       = (byte_go && !last_q) || fin_go;
	assign text_stall = cur_q && !free;
	assign load       = text_valid && !text_stall;

	always_ff @(posedge clk) begin
		if (load) begin
			b_q    <= text_byte;
			last_q <= end_of_buffer;
			off_q  <= boff_q;
		end
		if (byte_go && inscan_q) begin
			if (dcnt_q == 3'd1) db1_q <= b_q;
			if (dcnt_q == 3'd2) db2_q <= b_q;
			if (dcnt_q == 3'd0 && lead) begin
				db0_q    <= b_q;
				dstart_q <= off_q;
				need_q   <= (b_q[7:5] == 3'b110) ? 3'd2 : (b_q[7:4] == 4'b1110) ? 3'd3 : 3'd4;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_start_q <= '0;
			cur_q        <= 1'b0;
			inscan_q     <= 1'b0;
			emitted_q    <= 1'b0;
			stage_q      <= FS_PRE;
			fi_q         <= '0;
			dcnt_q       <= '0;
			boff_q       <= '0;
		end else begin
			if (scan_start_we) scan_start_q <= scan_start_wdata;
			if (flush_go) begin
				if (fi_q == 2'(dcnt_q - 3'd1)) begin
					dcnt_q <= '0;
					fi_q   <= '0;
					if (stage_q == FS_PRE) stage_q <= FS_BYTE;
				end else begin
					fi_q <= fi_q + 2'd1;
				end
			end
			if (byte_go) begin
				if (inscan_q) begin
					if (dcnt_q != 3'd0) dcnt_q <= complete ? 3'd0 : dcnt_q + 3'd1;
					else if (lead) dcnt_q <= 3'd1;
				end
				if (last_q) stage_q <= FS_POST;
			end
			if (load) begin
				cur_q     <= 1'b1;
				stage_q   <= FS_PRE;
				fi_q      <= '0;
				emitted_q <= 1'b0;
				inscan_q  <= (boff_q < OW'(MAX_BYTES)) &&
					(CW'(boff_q) >= CW'(scan_start_q));
				if (end_of_buffer) boff_q <= '0;
				else if (boff_q < OW'(MAX_BYTES)) boff_q <= boff_q + OW'(1);
			end else begin
				if (free) cur_q <= 1'b0;
				if (flush_go || (byte_go && byte_push)) emitted_q <= 1'b1;
			end
		end
	end
endmodule

[hdl/ues_back.sv]
// Back end: lookahead queue, sequence segmentation and result output.
module ues_back import ues_pkg::*; #(
	parameter int REPLAY_DEPTH = 4,
	parameter int OW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  op_hdr_t       op_hdr,
	input  logic [OW-1:0] op_off,
	output logic          op_pop,
	output logic          found,
	output logic [15:0]   seq_start,
	output logic [16:0]   seq_length,
	output logic          buffer_done,
	output logic          last_of_run,
	output logic          result_valid,
	input  logic          result_stall
);
	localparam int QC  = REPLAY_DEPTH + 4;
	localparam int QIW = $clog2(QC);
	localparam int QCW = $clog2(QC + 1);

	cls_t          cls_q [QC];
	logic [OW-1:0] off_q [QC];
	logic [OW-1:0] end_q [QC];
	logic [QCW-1:0] qc_q;
	bstate_t       st_q;
	logic          open_q, ended_q, final_q, send_q;
	logic [OW-1:0] start_q, comm_q;
	logic [1:0]    rcnt_q;

	logic          pend_v_q, pend_found_q, pend_done_q;
	logic [15:0]   pend_start_q;
	logic [16:0]   pend_len_q;
	logic          out_v_q, out_found_q, out_done_q, out_last_q;
	logic [15:0]   out_start_q;
	logic [16:0]   out_len_q;

	cls_t [4:0]    w0, w1;
	logic [4:0]    p0, p1;
	elem_t         e0, e1;
	act_t          act;
	logic [QIW-1:0] ridx;
	cls_t          rd_cls;
	logic [OW-1:0] rd_end;
	logic [2:0]    kk;
	logic          out_free, can_emit, em_want, go, move;
	logic          n_found, n_done;
	logic [15:0]   n_start;
	logic [16:0]   n_len;

	function automatic elem_t elem_f(input cls_t [4:0] w, input logic [4:0] p,
			input logic ended);
		elem_t r;
		logic [2:0] j;
		logic [2:0] t;
		logic wt;
		r.st = EL_NONE;
		r.n  = '0;
		j    = 3'd1;
		t    = 3'd0;
		wt   = 1'b0;
		if (!p[0]) begin
			r.st = ended ? EL_NONE : EL_WAIT;
		end else if (w[0].ri) begin
			if (!p[1] && !ended) r.st = EL_WAIT;
			else begin
				r.st = EL_FOUND;
				r.n  = (p[1] && w[1].ri) ? 3'd2 : 3'd1;
			end
		end else if (w[0].kb) begin
			if (!p[1] && !ended) wt = 1'b1;
			else if (p[1] && w[1].vs) j = 3'd2;
			if (!wt && j == 3'd2 && !p[2] && !ended) wt = 1'b1;
			if (wt) r.st = EL_WAIT;
			else if (p[j] && w[j].kc) begin
				r.st = EL_FOUND;
				r.n  = 3'(j + 3'd1);
			end
		end else if (w[0].dflt || w[0].md) begin
			if (!p[1] && !ended) wt = 1'b1;
			else if (p[1] && w[1].vs) begin
				j = 3'd2;
				if (!p[2] && !ended) wt = 1'b1;
			end
			if (!wt && p[j] && w[j].md && !w[0].md) begin
				j = 3'(j + 3'd1);
				if (!p[j] && !ended) wt = 1'b1;
			end
			r.st = EL_FOUND;
			r.n  = j;
			// tag run counts only when closed by the terminator
			if (!wt && p[j] && w[j].tag) begin
				t = 3'(j + 3'd1);
				if (!p[t] && !ended) wt = 1'b1;
				else if (p[t] && w[t].tend) r.n = 3'(t + 3'd1);
			end
			if (wt) begin
				r.st = EL_WAIT;
				r.n  = '0;
			end
		end else if (w[0].txt) begin
			if (!p[1] && !ended) r.st = EL_WAIT;
			else if (p[1] && w[1].vs) begin
				if (!p[2] && !ended) r.st = EL_WAIT;
				else begin
					r.st = EL_FOUND;
					r.n  = (p[2] && w[2].md) ? 3'd3 : 3'd2;
				end
			end
		end
		return r;
	endfunction

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			w0[k] = cls_q[k];
			w1[k] = cls_q[k + 1];
			p0[k] = QCW'(k) < qc_q;
			p1[k] = QCW'(k + 1) < qc_q;
		end
	end

	assign e0 = elem_f(w0, p0, ended_q);
	assign e1 = elem_f(w1, p1, ended_q);

	always_comb begin
		act = ACT_RET;
		if (!open_q) begin
			if (qc_q != '0) begin
				unique case (e0.st)
					EL_NONE:  act = ACT_DROP1;
					EL_FOUND: act = ACT_OPEN;
					default:  act = ACT_RET;
				endcase
			end
		end else if (!p0[0]) begin
			act = ended_q ? ACT_CLOSE : ACT_RET;
		end else if (!cls_q[0].zwj) begin
			act = ACT_CLOSE;
		end else begin
			unique case (e1.st)
				EL_NONE:  act = ACT_CLOSE;
				EL_FOUND: act = ACT_EXT;
				default:  act = ACT_RET;
			endcase
		end
	end

	always_comb begin
		if (st_q == BS_OP) ridx = QIW'(qc_q - QCW'(1));
		else if (act == ACT_OPEN) ridx = QIW'(e0.n - 3'd1);
		else ridx = QIW'(e1.n);
		rd_cls = cls_q[ridx];
		rd_end = end_q[ridx];
		case (act)
			ACT_OPEN: kk = e0.n;
			ACT_EXT:  kk = 3'(e1.n + 3'd1);
			default:  kk = 3'd1;
		endcase
	end

	assign out_free = !out_v_q || !result_stall;
	assign can_emit = !pend_v_q || out_free;
	assign em_want  = ((st_q == BS_RES && act == ACT_CLOSE) || st_q == BS_DONE) &&
		rcnt_q != 2'd3;
	assign go = (st_q == BS_END) ? (!pend_v_q || out_free) : (!em_want || can_emit);
	assign move = go && pend_v_q && (em_want || st_q == BS_END);
	assign op_pop = st_q == BS_OP && op_valid;

	assign n_found = st_q == BS_RES;
	assign n_done  = st_q == BS_DONE;
	assign n_start = (st_q == BS_RES) ? 16'(start_q) : 16'd0;
	assign n_len   = (st_q == BS_RES) ? 17'(comm_q - start_q) : 17'd0;

	always_ff @(posedge clk) begin
		if (st_q == BS_OP && op_valid && op_hdr.kind == OP_PUSH) begin
			if (qc_q != '0 && op_hdr.cls.tag && rd_cls.tag) begin
				end_q[ridx] <= rd_end + OW'(op_hdr.len);
			end else if (qc_q < QCW'(QC)) begin
				cls_q[QIW'(qc_q)] <= op_hdr.cls;
				off_q[QIW'(qc_q)] <= op_off;
				end_q[QIW'(qc_q)] <= op_off + OW'(op_hdr.len);
			end
		end
		if (st_q == BS_RES && go &&
				(act == ACT_DROP1 || act == ACT_OPEN || act == ACT_EXT)) begin
			for (int i = 0; i < QC; i++) begin
				if (i + int'(kk) < QC) begin
					cls_q[i] <= cls_q[i + int'(kk)];
					off_q[i] <= off_q[i + int'(kk)];
					end_q[i] <= end_q[i + int'(kk)];
				end
			end
		end
		if (st_q == BS_RES && go && act == ACT_OPEN) start_q <= off_q[0];
		if (st_q == BS_RES && go && (act == ACT_OPEN || act == ACT_EXT)) comm_q <= rd_end;
		if (go && em_want) begin
			pend_found_q <= n_found;
			pend_start_q <= n_start;
			pend_len_q   <= n_len;
			pend_done_q  <= n_done;
		end
		if (move) begin
			out_found_q <= pend_found_q;
			out_start_q <= pend_start_q;
			out_len_q   <= pend_len_q;
			out_done_q  <= pend_done_q;
			out_last_q  <= st_q == BS_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BS_OP;
			qc_q     <= '0;
			open_q   <= 1'b0;
			ended_q  <= 1'b0;
			final_q  <= 1'b0;
			send_q   <= 1'b0;
			rcnt_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (move) out_v_q <= 1'b1;
			else if (out_v_q && !result_stall) out_v_q <= 1'b0;
			if (go && em_want) pend_v_q <= 1'b1;
			else if (move) pend_v_q <= 1'b0;
			unique case (st_q)
				BS_OP: begin
					if (op_valid) begin
						case (op_hdr.kind)
							OP_PUSH: begin
								if (!(qc_q != '0 && op_hdr.cls.tag && rd_cls.tag) &&
										qc_q < QCW'(QC))
									qc_q <= qc_q + QCW'(1);
								send_q <= op_hdr.step_end;
								st_q   <= BS_RES;
							end
							OP_STEP: st_q <= BS_END;
							OP_FINAL: begin
								ended_q <= 1'b1;
								final_q <= 1'b1;
								st_q    <= BS_RES;
							end
							default: st_q <= BS_OP;
						endcase
					end
				end
				BS_RES: begin
					if (go) begin
						unique case (act)
							ACT_RET: st_q <= final_q ? BS_DONE : (send_q ? BS_END : BS_OP);
							ACT_CLOSE: open_q <= 1'b0;
							default: begin
								qc_q <= qc_q - QCW'(kk);
								if (act == ACT_OPEN) open_q <= 1'b1;
							end
						endcase
						if (em_want) rcnt_q <= rcnt_q + 2'd1;
					end
				end
				BS_DONE: begin
					if (go) begin
						if (em_want) rcnt_q <= rcnt_q + 2'd1;
						qc_q    <= '0;
						open_q  <= 1'b0;
						ended_q <= 1'b0;
						final_q <= 1'b0;
						st_q    <= BS_END;
					end
				end
				default: begin
					if (go) begin
						rcnt_q <= '0;
						send_q <= 1'b0;
						st_q   <= BS_OP;
					end
				end
			endcase
		end
	end

	assign result_valid = out_v_q;
	assign found        = out_found_q;
	assign seq_start    = out_start_q;
	assign seq_length   = out_len_q;
	assign buffer_done  = out_done_q;
	assign last_of_run  = out_last_q;

`ifndef NO_ASSERTIONS
	a_qc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qc_q <= QCW'(QC)) else $error("lookahead queue overfilled");
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BS_DONE && go) |=> (qc_q == '0 && !ended_q && !open_q))
		else $error("buffer end left state behind");
	a_done_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_done_q) |-> (!out_found_q && out_last_q))
		else $error("done beat malformed");
	a_open_span: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> comm_q > start_q) else $error("open sequence is empty");
`endif
endmodule

[hdl/utf8_emoji_sequence_scanner_unit.sv]
// Throughput: the front takes one byte per cycle while text_stall is low; dropped bytes of a broken
// character and a full queue raise text_stall; the back end pops a beat only after resolving the last.
// Reset: arst_n clears all control state and scan_start to 0; no clearing pass is needed.
// Output: a result register and a pending stage let results wait while input is accepted.
module utf8_emoji_sequence_scanner_unit import ues_pkg::*; #(
	parameter int MAX_BUFFER_BYTES = 65536,
	parameter int REPLAY_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        scan_start_we,
	input  logic [15:0] scan_start_wdata,
	input  logic [7:0]  text_byte,
	input  logic        end_of_buffer,
	input  logic        text_valid,
	output logic        text_stall,
	output logic        found,
	output logic [15:0] seq_start,
	output logic [16:0] seq_length,
	output logic        buffer_done,
	output logic        last_of_run,
	output logic        result_valid,
	input  logic        result_stall
);
	localparam int OW = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int HW = $bits(op_hdr_t);
	localparam int QW = HW + OW;

	logic          f_valid, q_full, q_valid, q_pop;
	op_hdr_t       f_hdr, b_hdr;
	logic [OW-1:0] f_off, b_off;
	logic [QW-1:0] q_rd;

	ues_front #(.MAX_BYTES(MAX_BUFFER_BYTES), .OW(OW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.scan_start_we(scan_start_we), .scan_start_wdata(scan_start_wdata),
		.text_byte(text_byte), .end_of_buffer(end_of_buffer),
		.text_valid(text_valid), .text_stall(text_stall),
		.op_valid(f_valid), .op_hdr(f_hdr), .op_off(f_off), .op_full(q_full)
	);

	ues_opq #(.W(QW)) u_opq (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_data({f_hdr, f_off}), .full(q_full),
		.rd_valid(q_valid), .rd_data(q_rd), .pop(q_pop)
	);

	assign b_hdr = op_hdr_t'(q_rd[QW-1:OW]);
	assign b_off = q_rd[OW-1:0];

	ues_back #(.REPLAY_DEPTH(REPLAY_DEPTH), .OW(OW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(q_valid), .op_hdr(b_hdr), .op_off(b_off), .op_pop(q_pop),
		.found(found), .seq_start(seq_start), .seq_length(seq_length),
		.buffer_done(buffer_done), .last_of_run(last_of_run),
		.result_valid(result_valid), .result_stall(result_stall)
	);
endmodule

[bench/ues_scan_checker.sv]
// Scoreboard for the emoji sequence scanner: predicts the result beats and compares them.
module ues_scan_checker import ues_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        scan_start_we,
	input  logic [15:0] scan_start_wdata,
	input  logic [7:0]  text_byte,
	input  logic        end_of_buffer,
	input  logic        text_valid,
	input  logic        text_stall,
	input  logic        found,
	input  logic [15:0] seq_start,
	input  logic [16:0] seq_length,
	input  logic        buffer_done,
	input  logic        last_of_run,
	input  logic        result_valid,
	input  logic        result_stall,
	output int          errors,
	output int          pending,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUF_MAX = 65536;
	localparam int LOOKAHEAD_CAP = 8;

	typedef struct {
		logic [20:0] cp;
		int unsigned off;
		int unsigned len;
	} cp_ent_t;

	typedef struct {
		logic        found;
		logic [15:0] start;
		logic [16:0] length;
		logic        done;
		logic        last;
	} scan_res_t;

	logic [15:0] start_reg;
	int unsigned byte_off;
	logic [7:0]  dec_bytes [4];
	int unsigned dec_cnt, dec_need, dec_start;
	cp_ent_t     lookahead [$];
	logic        seq_open;
	int unsigned open_start, commit_end;
	logic        ended;
	scan_res_t   step_res [$];
	scan_res_t   expected_res [$];

	assign pending = expected_res.size();

	function automatic logic in_dflt(logic [20:0] c);
		for (int i = 0; i < N_DFLT; i++)
			if (c >= DFLT_TAB[i][41:21] && c <= DFLT_TAB[i][20:0]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic in_text(logic [20:0] c);
		for (int i = 0; i < N_TEXT; i++)
			if (c >= TEXT_TAB[i][41:21] && c <= TEXT_TAB[i][20:0]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic is_mod(logic [20:0] c);
		return c >= CP_MOD_LO && c <= CP_MOD_HI;
	endfunction

	function automatic logic is_ri(logic [20:0] c);
		return c >= CP_RI_LO && c <= CP_RI_HI;
	endfunction

	function automatic logic is_tag(logic [20:0] c);
		return c >= CP_TAG_LO && c <= CP_TAG_HI;
	endfunction

	function automatic logic is_keybase(logic [20:0] c);
		return c == 21'h23 || c == 21'h2A || (c >= 21'h30 && c <= 21'h39);
	endfunction

	// 1 present, 0 stream over, -1 not known yet
	function automatic int peek_cp(int i, output logic [20:0] c);
		c = '0;
		if (i < lookahead.size()) begin
			c = lookahead[i].cp;
			return 1;
		end
		return ended ? 0 : -1;
	endfunction

	// -1 undecided, 0 no element, 1 element of n entries
	function automatic int match_element(int s, output int n);
		logic [20:0] c, x;
		int st, j, t;
		n = 0;
		j = s + 1;
		st = peek_cp(s, c);
		if (st <= 0) return st;
		if (is_ri(c)) begin
			st = peek_cp(j, x);
			if (st < 0) return -1;
			if (st == 1 && is_ri(x)) j++;
			n = j - s;
			return 1;
		end
		if (is_keybase(c)) begin
			st = peek_cp(j, x);
			if (st < 0) return -1;
			if (st == 1 && x == CP_VS16) begin
				j++;
				st = peek_cp(j, x);
				if (st < 0) return -1;
			end
			if (st == 1 && x == CP_COMBINING_KEY) begin
				n = j + 1 - s;
				return 1;
			end
			return 0;
		end
		if (in_dflt(c) || is_mod(c)) begin
			st = peek_cp(j, x);
			if (st < 0) return -1;
			if (st == 1 && x == CP_VS16) begin
				j++;
				st = peek_cp(j, x);
				if (st < 0) return -1;
			end
			if (st == 1 && is_mod(x) && !is_mod(c)) begin
				j++;
				st = peek_cp(j, x);
				if (st < 0) return -1;
			end
			if (st == 1 && is_tag(x)) begin
				t = j + 1;
				st = peek_cp(t, x);
				if (st < 0) return -1;
				if (st == 1 && x == CP_TAG_END) begin
					n = t + 1 - s;
					return 1;
				end
			end
			n = j - s;
			return 1;
		end
		if (in_text(c)) begin
			st = peek_cp(j, x);
			if (st < 0) return -1;
			if (st == 1 && x == CP_VS16) begin
				j++;
				st = peek_cp(j, x);
				if (st < 0) return -1;
				if (st == 1 && is_mod(x)) j++;
				n = j - s;
				return 1;
			end
			return 0;
		end
		return 0;
	endfunction

	function automatic void add_result(logic f, int unsigned st, int unsigned len, logic d);
		scan_res_t r;
		if (step_res.size() >= 3) return;
		if (len > BUF_MAX) len = BUF_MAX;
		r.found = f;
		r.start = st[15:0];
		r.length = len[16:0];
		r.done = d;
		r.last = 1'b0;
		step_res.push_back(r);
	endfunction

	function automatic void drop_front(int n);
		for (int i = 0; i < n && lookahead.size() > 0; i++) void'(lookahead.pop_front());
	endfunction

	function automatic void close_sequence();
		add_result(1'b1, open_start, commit_end - open_start, 1'b0);
		seq_open = 1'b0;
	endfunction

	function automatic void settle();
		int n, r;
		logic [20:0] c;
		while (1) begin
			if (!seq_open) begin
				if (lookahead.size() == 0) return;
				r = match_element(0, n);
				if (r < 0) return;
				if (r == 0) begin
					drop_front(1);
					continue;
				end
				open_start = lookahead[0].off;
				commit_end = lookahead[n - 1].off + lookahead[n - 1].len;
				drop_front(n);
				seq_open = 1'b1;
			end else begin
				r = peek_cp(0, c);
				if (r < 0) return;
				if (r == 0 || c != CP_ZWJ) begin
					close_sequence();
					continue;
				end
				r = match_element(1, n);
				if (r < 0) return;
				if (r == 0) begin
					close_sequence();
					continue;
				end
				commit_end = lookahead[n].off + lookahead[n].len;
				drop_front(n + 1);
			end
		end
	endfunction

	function automatic void push_cp(logic [20:0] c, int unsigned off, int unsigned len);
		cp_ent_t e;
		int k;
		k = lookahead.size();
		// a run of tag characters folds into one entry
		if (k > 0 && is_tag(c) && is_tag(lookahead[k - 1].cp)) begin
			lookahead[k - 1].len += len;
		end else if (k < LOOKAHEAD_CAP) begin
			e.cp = c;
			e.off = off;
			e.len = len;
			lookahead.push_back(e);
		end
		settle();
	endfunction

	function automatic void flush_partial();
		for (int unsigned i = 0; i < dec_cnt; i++) push_cp(CP_BAD, dec_start + i, 1);
		dec_cnt = 0;
	endfunction

	function automatic void decode_byte(logic [7:0] b, int unsigned off);
		logic [20:0] c;
		if (dec_cnt > 0) begin
			if (b[7:6] == 2'b10) begin
				dec_bytes[dec_cnt & 3] = b;
				dec_cnt++;
				if (dec_cnt >= dec_need) begin
					if (dec_need == 2)
						c = {10'd0, dec_bytes[0][4:0], dec_bytes[1][5:0]};
					else if (dec_need == 3)
						c = {5'd0, dec_bytes[0][3:0], dec_bytes[1][5:0], dec_bytes[2][5:0]};
					else
						c = {dec_bytes[0][2:0], dec_bytes[1][5:0], dec_bytes[2][5:0],
							dec_bytes[3][5:0]};
					dec_cnt = 0;
					push_cp(c, dec_start, dec_need);
				end
				return;
			end
			flush_partial();
		end
		if (b < 8'h80) begin
			push_cp({13'd0, b}, off, 1);
			return;
		end
		if (b[7:5] == 3'b110) dec_need = 2;
		else if (b[7:4] == 4'b1110) dec_need = 3;
		else if (b[7:3] == 5'b11110) dec_need = 4;
		else begin
			push_cp(CP_BAD, off, 1);
			return;
		end
		dec_bytes[0] = b;
		dec_cnt = 1;
		dec_start = off;
	endfunction

	function automatic void clear_buffer();
		byte_off = 0;
		foreach (dec_bytes[i]) dec_bytes[i] = '0;
		dec_cnt = 0;
		dec_need = 0;
		dec_start = 0;
		lookahead.delete();
		seq_open = 1'b0;
		open_start = 0;
		commit_end = 0;
		ended = 1'b0;
	endfunction

	function automatic void predict_beat(logic [7:0] b, logic eob);
		int unsigned off;
		off = byte_off;
		step_res.delete();
		if (off < BUF_MAX) begin
			if (off >= start_reg) decode_byte(b, off);
			byte_off = off + 1;
		end
		if (eob) begin
			flush_partial();
			ended = 1'b1;
			settle();
			add_result(1'b0, 0, 0, 1'b1);
			clear_buffer();
		end
		if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i]) expected_res.push_back(step_res[i]);
	endfunction

	function automatic void cmp_field(string name, longint unsigned e, longint unsigned a);
		if (e != a) begin
			$error("%s: expected %0h, actual %0h", name, e, a);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_res_t x;
		if (!arst_n) begin
			start_reg <= '0;
			clear_buffer();
			expected_res.delete();
			errors <= 0;
			checked <= 0;
		end else begin
			if (scan_start_we) start_reg <= scan_start_wdata;
			if (text_valid && !text_stall) predict_beat(text_byte, end_of_buffer);
			if (result_valid && !result_stall) begin
				checked <= checked + 1;
				if (expected_res.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					x = expected_res.pop_front();
					cmp_field("found", x.found, found);
					cmp_field("seq_start", x.start, seq_start);
					cmp_field("seq_length", x.length, seq_length);
					cmp_field("buffer_done", x.done, buffer_done);
					cmp_field("last_of_run", x.last, last_of_run);
				end
			end
		end
	end

endmodule

[bench/tb_utf8_emoji_sequence_scanner_unit.sv]
// Top level of the scanner testbench: clock, reset, byte stimulus and verdict.
module tb_utf8_emoji_sequence_scanner_unit import ues_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        scan_start_we = 1'b0;
	logic [15:0] scan_start_wdata = '0;
	logic [7:0]  text_byte = '0;
	logic        end_of_buffer = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_stall;
	logic        found;
	logic [15:0] seq_start;
	logic [16:0] seq_length;
	logic        buffer_done;
	logic        last_of_run;
	logic        result_valid;
	logic        result_stall = 1'b0;
	int          errors, pending, checked;

	logic [7:0]  buf_bytes [$];
	logic        calm = 1'b0;
	int          n_buffers = 0;
	int          n_bytes = 0;
	int          sink_hold = 0;

	utf8_emoji_sequence_scanner_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.scan_start_we(scan_start_we), .scan_start_wdata(scan_start_wdata),
		.text_byte(text_byte), .end_of_buffer(end_of_buffer),
		.text_valid(text_valid), .text_stall(text_stall),
		.found(found), .seq_start(seq_start), .seq_length(seq_length),
		.buffer_done(buffer_done), .last_of_run(last_of_run),
		.result_valid(result_valid), .result_stall(result_stall)
	);

	ues_scan_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.scan_start_we(scan_start_we), .scan_start_wdata(scan_start_wdata),
		.text_byte(text_byte), .end_of_buffer(end_of_buffer),
		.text_valid(text_valid), .text_stall(text_stall),
		.found(found), .seq_start(seq_start), .seq_length(seq_length),
		.buffer_done(buffer_done), .last_of_run(last_of_run),
		.result_valid(result_valid), .result_stall(result_stall),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("tb_utf8_emoji_sequence_scanner_unit NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side back-pressure, mostly short bursts
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			result_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			sink_hold <= pick_gap();
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic void put_cp(logic [20:0] c);
		if (c < 21'h80) begin
			buf_bytes.push_back(c[7:0]);
		end else if (c < 21'h800) begin
			buf_bytes.push_back({3'b110, c[10:6]});
			buf_bytes.push_back({2'b10, c[5:0]});
		end else if (c < 21'h10000) begin
			buf_bytes.push_back({4'b1110, c[15:12]});
			buf_bytes.push_back({2'b10, c[11:6]});
			buf_bytes.push_back({2'b10, c[5:0]});
		end else begin
			buf_bytes.push_back({5'b11110, c[20:18]});
			buf_bytes.push_back({2'b10, c[17:12]});
			buf_bytes.push_back({2'b10, c[11:6]});
			buf_bytes.push_back({2'b10, c[5:0]});
		end
	endfunction

	function automatic logic [20:0] any_mod();
		return 21'(CP_MOD_LO + $urandom_range(0, 4));
	endfunction

	function automatic logic [20:0] any_ri();
		return 21'(CP_RI_LO + $urandom_range(0, 25));
	endfunction

	function automatic logic [20:0] any_dflt();
		int i;
		i = $urandom_range(0, N_DFLT - 1);
		return 21'(DFLT_TAB[i][41:21] +
			$urandom_range(0, DFLT_TAB[i][20:0] - DFLT_TAB[i][41:21]));
	endfunction

	function automatic logic [20:0] any_text();
		int i;
		i = $urandom_range(0, N_TEXT - 1);
		return 21'(TEXT_TAB[i][41:21] +
			$urandom_range(0, TEXT_TAB[i][20:0] - TEXT_TAB[i][41:21]));
	endfunction

	function automatic logic [20:0] any_keybase();
		case ($urandom_range(0, 2))
			0: return 21'h23;
			1: return 21'h2A;
			default: return 21'(21'h30 + $urandom_range(0, 9));
		endcase
	endfunction

	function automatic void put_element();
		case ($urandom_range(0, 4))
			0: begin
				put_cp($urandom_range(0, 5) == 0 ? any_mod() : any_dflt());
				if ($urandom_range(0, 2) == 0) put_cp(CP_VS16);
				if ($urandom_range(0, 2) == 0) put_cp(any_mod());
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 4))
						put_cp(21'(CP_TAG_LO + $urandom_range(0, 94)));
					if ($urandom_range(0, 3) != 0) put_cp(CP_TAG_END);
				end
			end
			1: begin
				put_cp(any_ri());
				if ($urandom_range(0, 3) != 0) put_cp(any_ri());
			end
			2: begin
				put_cp(any_keybase());
				if ($urandom_range(0, 1) == 0) put_cp(CP_VS16);
				if ($urandom_range(0, 4) != 0) put_cp(CP_COMBINING_KEY);
			end
			default: begin
				put_cp(any_text());
				if ($urandom_range(0, 4) != 0) put_cp(CP_VS16);
				if ($urandom_range(0, 2) == 0) put_cp(any_mod());
			end
		endcase
	endfunction

	function automatic void put_noise();
		case ($urandom_range(0, 5))
			0, 1: buf_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			2: buf_bytes.push_back(8'($urandom_range(0, 255)));
			3: begin
				// lead byte followed by at most one continuation byte, often left incomplete
				buf_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
				if ($urandom_range(0, 1) == 0)
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end
			4: put_cp(CP_ZWJ);
			default: put_cp(21'($urandom_range(21'h80, 21'hFFFF)));
		endcase
	endfunction

	function automatic void build_random_buffer();
		buf_bytes.delete();
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(0, 3) == 0) begin
				put_noise();
			end else begin
				put_element();
				while ($urandom_range(0, 2) == 0) begin
					put_cp(CP_ZWJ);
					put_element();
				end
			end
		end
		if ($urandom_range(0, 7) == 0) buf_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
	endfunction

	task automatic send_byte(logic [7:0] b, logic eob);
		int g;
		text_byte <= b;
		end_of_buffer <= eob;
		text_valid <= 1'b1;
		do @(negedge clk); while (text_stall);
		@(posedge clk);
		n_bytes++;
		g = pick_gap();
		if (g > 0) begin
			text_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_buffer();
		foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
		n_buffers++;
	endtask

	task automatic drain();
		text_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_start(logic [15:0] v);
		drain();
		scan_start_we <= 1'b1;
		scan_start_wdata <= v;
		@(posedge clk);
		scan_start_we <= 1'b0;
	endtask

	initial begin
		int rnd_bytes;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_start(16'd0);
		// modifier sequence, then a ZWJ join to an element with a tag run
		buf_bytes.delete();
		put_cp(21'h1F600); put_cp(CP_VS16); put_cp(CP_MOD_HI);
		put_cp(CP_ZWJ); put_cp(21'h1F3F4);
		put_cp(CP_TAG_LO); put_cp(CP_TAG_HI); put_cp(CP_TAG_END);
		send_buffer();
		// flag pair, lone indicator, keycaps with and without VS16
		buf_bytes.delete();
		put_cp(CP_RI_LO); put_cp(CP_RI_HI); put_cp(CP_RI_LO); put_cp(21'h41);
		put_cp(21'h23); put_cp(CP_VS16); put_cp(CP_COMBINING_KEY);
		put_cp(21'h39); put_cp(CP_COMBINING_KEY);
		send_buffer();
		// text-default with VS16 and modifier, then a bare one
		buf_bytes.delete();
		put_cp(21'hA9); put_cp(CP_VS16); put_cp(CP_MOD_LO); put_cp(21'h2764);
		send_buffer();
		// malformed bytes: broken lead, stray continuation, F8..FF, overlong
		buf_bytes.delete();
		buf_bytes.push_back(8'hC3); buf_bytes.push_back(8'h41);
		buf_bytes.push_back(8'h80); buf_bytes.push_back(8'hFF); buf_bytes.push_back(8'hF8);
		buf_bytes.push_back(8'hC0); buf_bytes.push_back(8'hA3);
		buf_bytes.push_back(8'hF0); buf_bytes.push_back(8'h9F);
		send_buffer();
		// single byte buffer
		buf_bytes.delete();
		buf_bytes.push_back(8'h00);
		send_buffer();
		write_start(16'hFFFF);
		buf_bytes.delete();
		put_cp(21'h1F600); put_cp(21'h2614);
		send_buffer();
		write_start(16'd2);
		buf_bytes.delete();
		put_cp(21'h1F600); put_cp(21'h1F004);
		send_buffer();

		write_start(16'd0);
		rnd_bytes = 0;
		while (rnd_bytes < 280) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0: write_start(16'hFFFF);
					1: write_start(16'($urandom_range(1, 12)));
					default: write_start(16'd0);
				endcase
			end
			calm = ($urandom_range(0, 4) == 0);
			build_random_buffer();
			rnd_bytes += buf_bytes.size();
			send_buffer();
		end
		calm = 1'b0;

		text_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d buffers, %0d bytes, %0d result beats checked",
			n_buffers, n_bytes, checked);
		if (errors == 0 && pending == 0) begin
			$display("tb_utf8_emoji_sequence_scanner_unit OK");
		end else begin
			$display("tb_utf8_emoji_sequence_scanner_unit NOT OK");
		end
		$finish;
	end

endmodule

[utf8_emoji_sequence_scanner_unit.f]
hdl/ues_pkg.sv
hdl/ues_opq.sv
hdl/ues_front.sv
hdl/ues_back.sv
hdl/utf8_emoji_sequence_scanner_unit.sv
bench/ues_scan_checker.sv
bench/tb_utf8_emoji_sequence_scanner_unit.sv
